FILE: sv/fpsd_pkg.sv
// Shared types and constants for the fixed-point signed divider.
package fpsd_pkg;

  localparam int unsigned DATA_W = 32;

  // Control bits that ride along with each request through the cell chain.
  typedef struct packed {
    logic valid;
    logic neg;
    logic zero;
  } cell_ctl_t;

endpackage

FILE: sv/fpsd_in_if.sv
// Operand channel: dividend and divisor with valid/ready handshake.
interface fpsd_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpsd_pkg::DATA_W-1:0]  dividend;
  logic signed [fpsd_pkg::DATA_W-1:0]  divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

FILE: sv/fpsd_out_if.sv
// Result channel: signed quotient with valid/ready handshake.
interface fpsd_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [fpsd_pkg::DATA_W-1:0]  quotient;

  modport source (output valid, output quotient, input ready);
  modport sink   (input valid, input quotient, output ready);
endinterface

FILE: sv/fpsd_cell.sv
// One restoring-division cell: brings down one dividend bit and forms one quotient bit.
module fpsd_cell #(
  parameter int unsigned NUM_W = 48
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  fpsd_pkg::cell_ctl_t           ctl_in,
  input  logic [fpsd_pkg::DATA_W-1:0]   rem_in,
  input  logic [NUM_W-1:0]              num_in,
  input  logic [fpsd_pkg::DATA_W-1:0]   quot_in,
  input  logic [fpsd_pkg::DATA_W-1:0]   div_in,
  output fpsd_pkg::cell_ctl_t           ctl_out,
  output logic [fpsd_pkg::DATA_W-1:0]   rem_out,
  output logic [NUM_W-1:0]              num_out,
  output logic [fpsd_pkg::DATA_W-1:0]   quot_out,
  output logic [fpsd_pkg::DATA_W-1:0]   div_out
);

  localparam int unsigned W = fpsd_pkg::DATA_W;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         q_bit;
  logic [W-1:0] rem_next;

  always_comb begin
    shifted  = {rem_in, num_in[NUM_W-1]};
    diff     = {1'b0, shifted} - {2'b00, div_in};
    q_bit    = ~diff[W+1];
    // Remainder stays below the divisor, so 32 bits hold it either way.
    rem_next = q_bit ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.neg  <= ctl_in.neg;
      ctl_out.zero <= ctl_in.zero;
      rem_out      <= rem_next;
      num_out      <= {num_in[NUM_W-2:0], 1'b0};
      quot_out     <= {quot_in[W-2:0], q_bit};
      div_out      <= div_in;
    end
  end

endmodule

FILE: sv/fixed_point_signed_divide_unit.sv
// Signed fixed-point divider (FRAC_BITS fraction bits, Q16.16 by default). Takes one
// dividend/divisor request per cycle unless the chain holds, and returns the quotient
// truncated toward zero, low 32 bits kept (large quotients wrap); a zero divisor gives
// zero. The datapath is a chain of 32+FRAC_BITS restoring-division cells (FRAC_BITS is
// 16 for Q16.16), one quotient bit per cell, and throughput is one request per cycle
// while the chain is not held. The whole chain advances together; it holds while a
// finished result waits at the output and the sink is not ready.
module fixed_point_signed_divide_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  fpsd_in_if.sink           in,
  fpsd_out_if.source        out
);

  localparam int unsigned W      = fpsd_pkg::DATA_W;
  localparam int unsigned NUM_W  = W + FRAC_BITS;
  localparam int unsigned STAGES = NUM_W;

  fpsd_pkg::cell_ctl_t ctl  [STAGES+1];
  logic [W-1:0]        rem  [STAGES+1];
  logic [NUM_W-1:0]    num  [STAGES+1];
  logic [W-1:0]        quot [STAGES+1];
  logic [W-1:0]        dvs  [STAGES+1];

  logic         en;
  logic [W-1:0] a_raw;
  logic [W-1:0] b_raw;
  logic [W-1:0] a_mag;
  logic [W-1:0] b_mag;
  logic [W-1:0] q_last;

  assign en       = ~ctl[STAGES].valid | out.ready;
  assign in.ready = en;

  always_comb begin
    a_raw = in.dividend;
    b_raw = in.divisor;
    // Most negative value maps to 2^31 unsigned.
    a_mag = a_raw[W-1] ? (~a_raw + 1'b1) : a_raw;
    b_mag = b_raw[W-1] ? (~b_raw + 1'b1) : b_raw;
    ctl[0].valid = in.valid;
    ctl[0].neg   = a_raw[W-1] ^ b_raw[W-1];
    ctl[0].zero  = (b_raw == '0);
    rem[0]       = '0;
    num[0]       = {a_mag, {FRAC_BITS{1'b0}}};
    quot[0]      = '0;
    dvs[0]       = b_mag;
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    fpsd_cell #(
      .NUM_W (NUM_W)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .ctl_in   (ctl[i]),
      .rem_in   (rem[i]),
      .num_in   (num[i]),
      .quot_in  (quot[i]),
      .div_in   (dvs[i]),
      .ctl_out  (ctl[i+1]),
      .rem_out  (rem[i+1]),
      .num_out  (num[i+1]),
      .quot_out (quot[i+1]),
      .div_out  (dvs[i+1])
    );
  end

  always_comb begin
    q_last = quot[STAGES];
    if (ctl[STAGES].zero) begin
      out.quotient = '0;
    end else if (ctl[STAGES].neg) begin
      out.quotient = ~q_last + 1'b1;
    end else begin
      out.quotient = q_last;
    end
  end

  assign out.valid = ctl[STAGES].valid;

endmodule
